>>> rtl/sip_start_line_classifier_assert.svh
// Assertion macros for the start-line classifier checks.
// Both expect clk and arst_n in the scope where they are used.
`ifndef SIP_START_LINE_CLASSIFIER_ASSERT_SVH
`define SIP_START_LINE_CLASSIFIER_ASSERT_SVH

// Property checked at every rising edge outside reset.
`define SSLC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define SSLC_ASSERT_NEXT(lbl, ante, cons, msg) \
	`SSLC_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

>>> rtl/sslc_pkg.sv
package sslc_pkg;

	localparam int COUNT_BITS_DEF = 32;
	localparam int PREFIX_LEN     = 9;
	localparam int NUM_CLASSES    = 15;
	localparam int VER_LEN        = 6;

	typedef enum logic [3:0] {
		CLS_OTHER     = 4'd0,
		CLS_RESPONSE  = 4'd1,
		CLS_REGISTER  = 4'd2,
		CLS_REFER     = 4'd3,
		CLS_INVITE    = 4'd4,
		CLS_INFO      = 4'd5,
		CLS_ACK       = 4'd6,
		CLS_CANCEL    = 4'd7,
		CLS_PUBLISH   = 4'd8,
		CLS_SUBSCRIBE = 4'd9,
		CLS_MESSAGE   = 4'd10,
		CLS_OPTIONS   = 4'd11,
		CLS_NOTIFY    = 4'd12,
		CLS_PING      = 4'd13,
		CLS_BYE       = 4'd14
	} cls_t;

	typedef logic [PREFIX_LEN-1:0][7:0] prefix_t;

	typedef struct packed {
		cls_t cls;
		logic is_method;
	} verdict_t;

	// Character of "SIP/2." expected after prog bytes have matched.
	function automatic logic [7:0] ver_char(input logic [2:0] prog);
		logic [7:0] c;
		case (prog)
			3'd0: c = "S";
			3'd1: c = "I";
			3'd2: c = "P";
			3'd3: c = "/";
			3'd4: c = "2";
			3'd5: c = ".";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// txt holds len characters right-aligned, first character highest.
	function automatic logic has_prefix(input prefix_t p, input logic [3:0] cnt,
			input logic [8*PREFIX_LEN-1:0] txt, input int len);
		logic [8*PREFIX_LEN-1:0] t;
		logic ok;
		t  = txt << (8 * (PREFIX_LEN - len));
		ok = (32'(cnt) >= len);
		for (int i = 0; i < PREFIX_LEN; i++) begin
			if (i < len && p[i] != t[8*PREFIX_LEN-1-8*i -: 8])
				ok = 1'b0;
		end
		return ok;
	endfunction

	function automatic verdict_t classify(input prefix_t p, input logic [3:0] cnt);
		verdict_t v;
		v.is_method = 1'b1;
		if (has_prefix(p, cnt, 72'("SIP/2."), 6)) begin
			v.cls       = CLS_RESPONSE;
			v.is_method = 1'b0;
		end else if (has_prefix(p, cnt, 72'("REGISTER"), 8))  v.cls = CLS_REGISTER;
		else if (has_prefix(p, cnt, 72'("REFER"), 5))       v.cls = CLS_REFER;
		else if (has_prefix(p, cnt, 72'("INVITE"), 6))      v.cls = CLS_INVITE;
		else if (has_prefix(p, cnt, 72'("INFO"), 4))        v.cls = CLS_INFO;
		else if (has_prefix(p, cnt, 72'("ACK"), 3))         v.cls = CLS_ACK;
		else if (has_prefix(p, cnt, 72'("CANCEL"), 6))      v.cls = CLS_CANCEL;
		else if (has_prefix(p, cnt, 72'("PUBLISH"), 7))     v.cls = CLS_PUBLISH;
		else if (has_prefix(p, cnt, 72'("SUBSCRIBE"), 9))   v.cls = CLS_SUBSCRIBE;
		else if (has_prefix(p, cnt, 72'("MESSAGE"), 7))     v.cls = CLS_MESSAGE;
		else if (has_prefix(p, cnt, 72'("OPTIONS"), 7))     v.cls = CLS_OPTIONS;
		else if (has_prefix(p, cnt, 72'("NOTIFY"), 6))      v.cls = CLS_NOTIFY;
		else if (has_prefix(p, cnt, 72'("PING"), 4))        v.cls = CLS_PING;
		else if (has_prefix(p, cnt, 72'("BYE"), 3))         v.cls = CLS_BYE;
		else begin
			v.cls       = CLS_OTHER;
			v.is_method = 1'b0;
		end
		return v;
	endfunction

endpackage

>>> rtl/sip_start_line_classifier.sv
// The result of a packet follows its last byte from s1 through the classify stage, then the
// counter update writes it into the output register.
// Throughput: one byte per cycle, back to back, also across packet boundaries; while both
// the classify stage and a stalled output register hold results, a last byte waits in s1.
// arst_n clears all class counters, the request counter, the match state and
// every valid flag; stored prefix bytes and payload registers are not reset.
module sip_start_line_classifier
	import sslc_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [31:0] class_count, [63:32] request_count
	output logic [4:0]  m_tuser    // [3:0] packet_class, [4] version_seen
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// per-packet state
	prefix_t    prefix_q;
	logic [3:0] pos_q;
	logic [2:0] prog_q;
	logic       found_q;

	// classify stage
	logic       valid_s2;
	cls_t       cls_s2;
	logic       ver_s2;
	logic       method_s2;

	// counters
	logic [COUNT_BITS-1:0] cnt_q [NUM_CLASSES];
	logic [COUNT_BITS-1:0] req_q;

	// output register
	logic        out_valid_q;
	cls_t        out_cls_q;
	logic        out_ver_q;
	logic [31:0] out_ccnt_q;
	logic [31:0] out_rcnt_q;

	logic out_free, s2_free, s1_go, s2_go;

	assign out_free = !out_valid_q || m_tready;
	assign s2_free  = !valid_s2 || out_free;
	assign s1_go    = valid_s1 && (!last_s1 || s2_free);
	assign s2_go    = valid_s2 && out_free;
	assign s_tready = !valid_s1 || s1_go;

	// byte update
	prefix_t    prefix_d;
	logic [3:0] count_d;
	logic [2:0] prog_d;
	logic       found_d;
	logic [2:0] prog_inc;
	verdict_t   verdict;

	always_comb begin
		for (int i = 0; i < PREFIX_LEN; i++) begin
			prefix_d[i] = (pos_q == 4'(i)) ? byte_s1 : prefix_q[i];
		end
		count_d = (pos_q == 4'hF) ? pos_q : pos_q + 4'd1;

		prog_inc = prog_q + 3'd1;
		if (byte_s1 == ver_char(prog_q))
			prog_d = prog_inc;
		else
			prog_d = (byte_s1 == "S") ? 3'd1 : 3'd0;
		// an occurrence may not start at the first byte
		if (pos_q == 4'd0)
			prog_d = 3'd0;
		found_d = found_q;
		if (prog_d == 3'(VER_LEN)) begin
			found_d = 1'b1;
			prog_d  = 3'd0;
		end

		verdict = classify(prefix_d, count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			prog_q  <= '0;
			found_q <= 1'b0;
		end else if (s1_go) begin
			if (last_s1) begin
				pos_q   <= '0;
				prog_q  <= '0;
				found_q <= 1'b0;
			end else begin
				pos_q   <= count_d;
				prog_q  <= prog_d;
				found_q <= found_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go)
			prefix_q <= prefix_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_go && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (s2_go) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			cls_s2    <= verdict.cls;
			ver_s2    <= found_d;
			method_s2 <= verdict.is_method;
		end
	end

	// counter read-modify-write
	logic [COUNT_BITS-1:0] sel_cnt, cnt_new, req_new;
	logic [COUNT_BITS+31:0] cnt_ext, req_ext;

	always_comb begin
		sel_cnt = '0;
		for (int i = 0; i < NUM_CLASSES; i++) begin
			if (cls_s2 == cls_t'(i))
				sel_cnt = cnt_q[i];
		end
		cnt_new = sel_cnt + COUNT_BITS'(1);
		req_new = (method_s2 && ver_s2) ? req_q + COUNT_BITS'(1) : req_q;
		cnt_ext = {32'd0, cnt_new};
		req_ext = {32'd0, req_new};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				cnt_q[i] <= '0;
			end
			req_q <= '0;
		end else if (s2_go) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				if (cls_s2 == cls_t'(i))
					cnt_q[i] <= cnt_new;
			end
			req_q <= req_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go) begin
			out_cls_q  <= cls_s2;
			out_ver_q  <= ver_s2;
			out_ccnt_q <= cnt_ext[31:0];
			out_rcnt_q <= req_ext[31:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_rcnt_q, out_ccnt_q};
	assign m_tuser  = {out_ver_q, out_cls_q};

endmodule

>>> rtl/sslc_checker.sv
`include "sip_start_line_classifier_assert.svh"

module sslc_checker
	import sslc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic [4:0]  m_tuser
);

	logic [31:0] prev_req_q;
	logic        have_q;
	logic        bump;
	cls_t        cls;

	assign cls  = cls_t'(m_tuser[3:0]);
	assign bump = m_tuser[4] && cls >= CLS_REGISTER && cls <= CLS_BYE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q     <= 1'b0;
			prev_req_q <= '0;
		end else if (m_tvalid && m_tready) begin
			have_q     <= 1'b1;
			prev_req_q <= m_tdata[63:32];
		end
	end

	`SSLC_ASSERT_NEXT(a_valid_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

	`SSLC_ASSERT_NEXT(a_data_hold, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	`SSLC_ASSERT(a_req_step, (m_tvalid && m_tready && have_q) |-> (m_tdata[63:32] == prev_req_q + 32'(bump)), "request count step wrong")

endmodule

bind sip_start_line_classifier sslc_checker u_sslc_checker (.*);
